### hdl/tsp_pkg.sv
// Shared types and constants for the traffic storm policer.
`timescale 1ns / 1ps

package tsp_pkg;

    // Class enable bits in the class mask register
    localparam logic [2:0] MASK_UNKNOWN_UNICAST = 3'h1;
    localparam logic [2:0] MASK_BROADCAST       = 3'h2;
    localparam logic [2:0] MASK_MULTICAST       = 3'h4;

    // Bit mode multiplies the byte count by eight: a left shift by three
    localparam int BITS_PER_BYTE  = 8;
    localparam int BYTE_SHIFT     = $clog2(BITS_PER_BYTE);

    // Register reset values
    localparam logic [2:0]  CLASS_MASK_RESET   = 3'd2;
    localparam logic        RATE_MODE_RESET    = 1'b0;
    localparam logic [31:0] THRESHOLD_RESET    = 32'd1000;
    localparam logic [15:0] WINDOW_TICKS_RESET = 16'd1000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CLASS_MASK   = 2'd0,
        REG_RATE_MODE    = 2'd1,
        REG_THRESHOLD    = 2'd2,
        REG_WINDOW_TICKS = 2'd3
    } reg_index_t;

    // Packet class codes
    typedef enum logic [1:0] {
        CLASS_KNOWN_UNICAST   = 2'd0,
        CLASS_BROADCAST       = 2'd1,
        CLASS_MULTICAST       = 2'd2,
        CLASS_UNKNOWN_UNICAST = 2'd3
    } packet_class_t;

    // Request actions
    localparam logic ACTION_PACKET = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    // Input request payload
    typedef struct packed {
        logic        action;
        logic [1:0]  packet_class;
        logic [15:0] packet_length;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic drop;
        logic blocking;
        logic window_end;
        logic over_threshold;
    } out_item_t;

    // Configuration bundle from the register file to the engine
    typedef struct packed {
        logic [2:0]  class_mask;
        logic        rate_mode;
        logic [31:0] threshold;
        logic [15:0] window_ticks;
    } cfg_t;

endpackage

### hdl/tsp_cfg_regs.sv
// Configuration register file of the traffic storm policer.
`timescale 1ns / 1ps

module tsp_cfg_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output tsp_pkg::cfg_t  cfg
);

    tsp_pkg::cfg_t cfg_reg;
    tsp_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (tsp_pkg::reg_index_t'(cfg_index))
                tsp_pkg::REG_CLASS_MASK:   cfg_next.class_mask   = cfg_data[2:0];
                tsp_pkg::REG_RATE_MODE:    cfg_next.rate_mode    = cfg_data[0];
                tsp_pkg::REG_THRESHOLD:    cfg_next.threshold    = cfg_data;
                tsp_pkg::REG_WINDOW_TICKS: cfg_next.window_ticks = cfg_data[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold register values, load reset defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.class_mask   <= tsp_pkg::CLASS_MASK_RESET;
            cfg_reg.rate_mode    <= tsp_pkg::RATE_MODE_RESET;
            cfg_reg.threshold    <= tsp_pkg::THRESHOLD_RESET;
            cfg_reg.window_ticks <= tsp_pkg::WINDOW_TICKS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/tsp_engine.sv
// Policer state and per-request update logic.
`timescale 1ns / 1ps

module tsp_engine #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  tsp_pkg::in_item_t   req,
    input  tsp_pkg::cfg_t       cfg,
    output tsp_pkg::out_item_t  res
);

    // Compare width covers count * 8 and the 32-bit threshold
    localparam int SHIFT_WIDTH = COUNT_WIDTH + tsp_pkg::BYTE_SHIFT;
    localparam int MEAS_WIDTH  = (SHIFT_WIDTH > 32) ? SHIFT_WIDTH : 32;

    logic                   blocking_reg, blocking_next;
    logic                   running_reg, running_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [15:0]            tick_reg, tick_next;

    logic                   watched;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] count_sat;
    logic [15:0]            amount;
    logic [15:0]            tick_inc;
    logic [15:0]            limit;
    logic [MEAS_WIDTH-1:0]  measure;
    logic                   over;

    // Classify the packet against the mask
    always_comb begin
        case (tsp_pkg::packet_class_t'(req.packet_class))
            tsp_pkg::CLASS_BROADCAST:
                watched = (cfg.class_mask & tsp_pkg::MASK_BROADCAST) != 3'd0;
            tsp_pkg::CLASS_MULTICAST:
                watched = (cfg.class_mask & tsp_pkg::MASK_MULTICAST) != 3'd0;
            tsp_pkg::CLASS_UNKNOWN_UNICAST:
                watched = (cfg.class_mask & tsp_pkg::MASK_UNKNOWN_UNICAST) != 3'd0;
            default:
                watched = 1'b0;
        endcase
    end

    // Saturating count add, window tick and threshold compare
    assign amount    = cfg.rate_mode ? req.packet_length : 16'd1;
    assign sum       = {1'b0, count_reg} + (COUNT_WIDTH + 1)'(amount);
    assign count_sat = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    assign tick_inc  = tick_reg + 16'd1;
    assign limit     = (cfg.window_ticks == 16'd0) ? 16'd1 : cfg.window_ticks;
    assign measure   = cfg.rate_mode ? (MEAS_WIDTH'(count_reg) << tsp_pkg::BYTE_SHIFT)
                                     : MEAS_WIDTH'(count_reg);
    assign over      = measure >= MEAS_WIDTH'(cfg.threshold);

    // Next state and result for the current request
    always_comb begin
        blocking_next = blocking_reg;
        running_next  = running_reg;
        count_next    = count_reg;
        tick_next     = tick_reg;
        res           = '0;
        if (req.action == tsp_pkg::ACTION_PACKET) begin
            if (watched) begin
                // open a window when idle
                if (!blocking_reg && !running_reg) begin
                    running_next = 1'b1;
                    tick_next    = 16'd0;
                end
                count_next = count_sat;
                res.drop   = blocking_reg;
            end
        end else if (running_reg) begin
            tick_next = tick_inc;
            if (tick_inc >= limit) begin
                res.window_end = 1'b1;
                if (over) begin
                    res.over_threshold = 1'b1;
                    blocking_next      = 1'b1;
                end else begin
                    blocking_next = 1'b0;
                    running_next  = 1'b0;
                end
                count_next = '0;
                tick_next  = 16'd0;
            end
        end
        res.blocking = blocking_next;
    end

    // Advance state on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocking_reg <= 1'b0;
            running_reg  <= 1'b0;
            count_reg    <= '0;
            tick_reg     <= 16'd0;
        end else if (accept) begin
            blocking_reg <= blocking_next;
            running_reg  <= running_next;
            count_reg    <= count_next;
            tick_reg     <= tick_next;
        end
    end

    // A threshold hit is only reported on a closing window
    a_over_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        res.over_threshold |-> res.window_end)
        else $error("over_threshold without window_end");

    // A closed window restarts from zero
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.window_end) |=> (count_reg == '0 && tick_reg == 16'd0))
        else $error("counters not cleared at window end");

    // Blocking starts only from an over-threshold window end
    a_block_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(blocking_reg) |-> $past(accept && res.over_threshold))
        else $error("blocking rose without threshold hit");

endmodule

### hdl/traffic_storm_policer.sv
// Top level of the traffic storm policer: config port, engine and result register.
`timescale 1ns / 1ps

// Storm policer for one port. Each request is a packet descriptor or one time
// tick, and each produces exactly one result (drop, blocking, window_end,
// over_threshold). A request is taken in every cycle in which s_ready is high: the
// policer state updates in the cycle of acceptance and the result appears in the
// registered output in the next cycle, so throughput is one request per cycle while
// the consumer keeps m_ready high. s_ready stays high while the result register
// is empty or being emptied. Configuration writes take effect on the next cycle
// and are expected only while no request is in flight.
module traffic_storm_policer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsp_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tsp_pkg::out_item_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    tsp_pkg::cfg_t      cfg;
    tsp_pkg::out_item_t res;
    tsp_pkg::out_item_t m_data_reg;
    logic               m_valid_reg, m_valid_next;
    logic               accept;

    tsp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsp_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (s_data),
        .cfg     (cfg),
        .res     (res)
    );

    // Accept while the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### tb/traffic_storm_policer_tb.sv
// Self-checking testbench for the traffic storm policer: directed table and random phases.
`timescale 1ns / 1ps

module traffic_storm_policer_tb;

    localparam int COUNT_W = 32;

    // One row of the directed plan: a register write or a request
    typedef struct {
        bit                  is_cfg;
        tsp_pkg::reg_index_t idx;
        logic [31:0]         val;
        tsp_pkg::in_item_t   req;
        bit                  typed;
        tsp_pkg::out_item_t  want;
    } plan_row_t;

    // Verdict typed into the plan for a request, if any
    typedef struct {
        bit                 known;
        tsp_pkg::out_item_t value;
    } typed_verdict_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    tsp_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    tsp_pkg::out_item_t m_data;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data  = '0;

    // Idle rates of the current phase, in percent
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Policer shadow: registers and state
    logic [2:0]         sh_mask;
    logic               sh_mode;
    logic [31:0]        sh_threshold;
    logic [15:0]        sh_window;
    logic               pol_blocking;
    logic               pol_window_open;
    logic [COUNT_W-1:0] pol_count;
    logic [15:0]        pol_ticks;

    tsp_pkg::out_item_t verdict_q[$];
    typed_verdict_t     typed_q[$];
    plan_row_t          plan[$];

    int mismatches = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_windows = 0;
    int n_over = 0;
    int n_drops = 0;

    traffic_storm_policer #(
        .COUNT_WIDTH(COUNT_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Stall the result channel at the phase rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Advance the shadow policer by one request and return its verdict
    function automatic tsp_pkg::out_item_t police_step(tsp_pkg::in_item_t req);
        tsp_pkg::out_item_t r;
        logic               watched;
        logic [15:0]        limit;
        logic [COUNT_W:0]   sum;
        logic [COUNT_W+2:0] measure;
        r = '0;
        watched = 1'b0;
        if (req.action == tsp_pkg::ACTION_PACKET) begin
            case (tsp_pkg::packet_class_t'(req.packet_class))
                tsp_pkg::CLASS_BROADCAST:
                    watched = (sh_mask & tsp_pkg::MASK_BROADCAST) != 3'd0;
                tsp_pkg::CLASS_MULTICAST:
                    watched = (sh_mask & tsp_pkg::MASK_MULTICAST) != 3'd0;
                tsp_pkg::CLASS_UNKNOWN_UNICAST:
                    watched = (sh_mask & tsp_pkg::MASK_UNKNOWN_UNICAST) != 3'd0;
                default:
                    watched = 1'b0;
            endcase
            if (watched) begin
                // Open a window on the first watched packet while idle
                if (!pol_blocking && !pol_window_open) begin
                    pol_window_open = 1'b1;
                    pol_ticks = '0;
                end
                sum = {1'b0, pol_count} +
                      (COUNT_W+1)'(sh_mode ? req.packet_length : 16'd1);
                pol_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
                r.drop = pol_blocking;
            end
        end else if (pol_window_open) begin
            limit = (sh_window == 16'd0) ? 16'd1 : sh_window;
            pol_ticks = pol_ticks + 16'd1;
            if (pol_ticks >= limit) begin
                // Compare bits exactly: count times eight needs three more bits
                measure = sh_mode ? {pol_count, 3'b000} : {3'b000, pol_count};
                r.window_end = 1'b1;
                if (measure >= (COUNT_W+3)'(sh_threshold)) begin
                    r.over_threshold = 1'b1;
                    pol_blocking = 1'b1;
                end else begin
                    pol_blocking = 1'b0;
                    pol_window_open = 1'b0;
                end
                pol_count = '0;
                pol_ticks = '0;
            end
        end
        r.blocking = pol_blocking;
        return r;
    endfunction

    // Track config writes, predict accepted requests, check results
    always @(posedge aclk) begin : scoreboard
        tsp_pkg::out_item_t want;
        tsp_pkg::out_item_t guess;
        typed_verdict_t     tv;
        bit                 bad;
        if (!aresetn) begin
            sh_mask = tsp_pkg::CLASS_MASK_RESET;
            sh_mode = tsp_pkg::RATE_MODE_RESET;
            sh_threshold = tsp_pkg::THRESHOLD_RESET;
            sh_window = tsp_pkg::WINDOW_TICKS_RESET;
            pol_blocking = 1'b0;
            pol_window_open = 1'b0;
            pol_count = '0;
            pol_ticks = '0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (m_data.window_end === 1'b1) n_windows++;
                if (m_data.over_threshold === 1'b1) n_over++;
                if (m_data.drop === 1'b1) n_drops++;
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result %b", $realtime, m_data);
                end else begin
                    want = verdict_q.pop_front();
                    bad = (m_data.drop !== want.drop) ||
                          (m_data.blocking !== want.blocking) ||
                          (m_data.window_end !== want.window_end) ||
                          (m_data.over_threshold !== want.over_threshold);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] result %0d: drop %b/%b blocking %b/%b ",
                                      "end %b/%b over %b/%b (exp/got)"},
                                     $realtime, n_results,
                                     want.drop, m_data.drop,
                                     want.blocking, m_data.blocking,
                                     want.window_end, m_data.window_end,
                                     want.over_threshold, m_data.over_threshold);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (tsp_pkg::reg_index_t'(cfg_index))
                    tsp_pkg::REG_CLASS_MASK:   sh_mask = cfg_data[2:0];
                    tsp_pkg::REG_RATE_MODE:    sh_mode = cfg_data[0];
                    tsp_pkg::REG_THRESHOLD:    sh_threshold = cfg_data;
                    tsp_pkg::REG_WINDOW_TICKS: sh_window = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                n_requests++;
                guess = police_step(s_data);
                tv.known = 1'b0;
                tv.value = '0;
                if (typed_q.size() != 0) tv = typed_q.pop_front();
                verdict_q.push_back(tv.known ? tv.value : guess);
            end
        end
    end

    // Hold one request on the input channel until it is accepted
    task automatic send_request(tsp_pkg::in_item_t req, bit known,
                                tsp_pkg::out_item_t want);
        typed_verdict_t tv;
        tv.known = known;
        tv.value = want;
        typed_q.push_back(tv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (verdict_q.size() != 0) @(negedge aclk);
        @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write one register while the policer is idle
    task automatic cfg_write(tsp_pkg::reg_index_t idx, logic [31:0] val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void add_req(logic act, logic [1:0] cls, logic [15:0] len,
                                    bit typed, logic [3:0] want);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx = tsp_pkg::REG_CLASS_MASK;
        row.val = '0;
        row.req.action = act;
        row.req.packet_class = cls;
        row.req.packet_length = len;
        row.typed = typed;
        row.want = tsp_pkg::out_item_t'(want);
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(tsp_pkg::reg_index_t idx, logic [31:0] val);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        row.req = '0;
        row.typed = 1'b0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    // Random request: ticks and packets of every class, lengths biased to the edges
    function automatic tsp_pkg::in_item_t random_request();
        tsp_pkg::in_item_t r;
        int                sel;
        r.action = ($urandom_range(0, 99) < 45) ? tsp_pkg::ACTION_TICK
                                                : tsp_pkg::ACTION_PACKET;
        r.packet_class = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel == 0) r.packet_length = 16'd0;
        else if (sel == 1) r.packet_length = 16'hFFFF;
        else if (sel < 6) r.packet_length = 16'($urandom_range(0, 255));
        else r.packet_length = 16'($urandom);
        return r;
    endfunction

    initial begin
        int          send_pct[4];
        int          stall_pct[4];
        logic        mode;
        logic [31:0] thr;
        logic [15:0] win;

        send_pct  = '{0, 67, 0, 28};
        stall_pct = '{0, 0, 67, 28};

        // Directed plan, starting from reset values
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0000);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0000);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_BROADCAST, 16'hFFFF, 1, 4'b0000);
        add_cfg(tsp_pkg::REG_CLASS_MASK, 32'd7);
        add_cfg(tsp_pkg::REG_THRESHOLD, 32'd1);
        add_cfg(tsp_pkg::REG_WINDOW_TICKS, 32'd0);
        // Zero window length closes on the first tick
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_MULTICAST, 16'h1234, 1, 4'b0111);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_MULTICAST, 16'd100, 1, 4'b1100);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_UNKNOWN_UNICAST, 16'hFFFF, 1,
                4'b1100);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_UNKNOWN_UNICAST, 16'hFFFF, 1,
                4'b0111);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_BROADCAST, 16'd0, 1, 4'b0010);
        add_cfg(tsp_pkg::REG_THRESHOLD, 32'd16);
        add_cfg(tsp_pkg::REG_WINDOW_TICKS, 32'd2);
        add_cfg(tsp_pkg::REG_CLASS_MASK, 32'd2);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_BROADCAST, 16'd3, 1, 4'b0000);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_BROADCAST, 16'd1, 1, 4'b0000);
        // Switch to bit mode with the window open
        add_cfg(tsp_pkg::REG_RATE_MODE, 32'd1);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0000);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0111);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_MULTICAST, 16'd9, 1, 4'b0100);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_KNOWN_UNICAST, 16'hFFFF, 1,
                4'b0100);
        add_cfg(tsp_pkg::REG_THRESHOLD, 32'd0);
        add_cfg(tsp_pkg::REG_RATE_MODE, 32'd0);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0100);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0111);
        add_cfg(tsp_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0100);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 1, 4'b0010);
        add_cfg(tsp_pkg::REG_CLASS_MASK, 32'd1);
        add_cfg(tsp_pkg::REG_RATE_MODE, 32'd1);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_UNKNOWN_UNICAST, 16'd0, 1, 4'b0000);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_BROADCAST, 16'hFFFF, 1, 4'b0000);
        add_req(tsp_pkg::ACTION_PACKET, tsp_pkg::CLASS_UNKNOWN_UNICAST, 16'hFFFF, 0,
                4'b0000);
        add_cfg(tsp_pkg::REG_WINDOW_TICKS, 32'd1);
        add_req(tsp_pkg::ACTION_TICK, tsp_pkg::CLASS_KNOWN_UNICAST, 16'd0, 0, 4'b0000);

        // Hold reset, then release
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed plan
        foreach (plan[i]) begin
            if (plan[i].is_cfg) cfg_write(plan[i].idx, plan[i].val);
            else send_request(plan[i].req, plan[i].typed, plan[i].want);
        end

        // Random phases, each with fresh settings and one of four idle patterns
        for (int p = 0; p < 8; p++) begin
            mode = 1'($urandom_range(0, 1));
            if (mode) thr = 32'($urandom_range(0, 1 << 20));
            else thr = 32'($urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0)
                thr = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            win = 16'($urandom_range(1, 6));
            if ($urandom_range(0, 7) == 0)
                win = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
            cfg_write(tsp_pkg::REG_CLASS_MASK, 32'($urandom_range(0, 7)));
            cfg_write(tsp_pkg::REG_RATE_MODE, 32'(mode));
            cfg_write(tsp_pkg::REG_THRESHOLD, thr);
            cfg_write(tsp_pkg::REG_WINDOW_TICKS, 32'(win));
            send_idle_pct = send_pct[p % 4];
            recv_stall_pct = stall_pct[p % 4];
            repeat (150) send_request(random_request(), 0, '0);
        end

        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge aclk);
        if (verdict_q.size() != 0) mismatches++;

        $display("Checked %0d results for %0d requests: %0d windows closed, %0d over,",
                 n_results, n_requests, n_windows, n_over);
        $display("%0d drops, %0d mismatches", n_drops, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
